/* design/cts_pkg.sv */
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the token scanner
// Kind and error codes, field widths and the classified-beat record.
// ----------------------------------------------------------------------------
`default_nettype none
package cts_pkg;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int KIND_W   = 6;
    localparam int LEN_W    = 16;
    localparam int VAL_W    = 32;
    localparam int ERR_W    = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [KIND_W-1:0] K_LT = 6'd0, K_GT = 6'd1, K_LE = 6'd2, K_GE = 6'd3,
        K_SHL = 6'd4, K_SHR = 6'd5, K_ARROW = 6'd6, K_DEC = 6'd7, K_EQ = 6'd8,
        K_NE = 6'd9, K_PLUS = 6'd10, K_MINUS = 6'd11, K_STAR = 6'd12,
        K_PCT = 6'd14, K_ADDEQ = 6'd15, K_SUBEQ = 6'd16, K_MULEQ = 6'd17,
        K_MODEQ = 6'd19, K_OROR = 6'd20, K_ANDAND = 6'd21, K_INC = 6'd22,
        K_EOI = 6'd23, K_IF = 6'd24, K_INT = 6'd25, K_LBRK = 6'd26,
        K_RBRK = 6'd27, K_LBRC = 6'd28, K_RBRC = 6'd29, K_LPAR = 6'd30,
        K_RPAR = 6'd31, K_SEMI = 6'd32, K_COMMA = 6'd33, K_TILDE = 6'd34,
        K_AMP = 6'd35, K_BAR = 6'd36, K_CARET = 6'd37, K_BANG = 6'd38,
        K_ANDEQ = 6'd39, K_OREQ = 6'd40, K_XOREQ = 6'd41, K_HASH = 6'd43,
        K_ASSIGN = 6'd45, K_QUEST = 6'd46, K_IDENT = 6'd47, K_CONST = 6'd48,
        K_NONE = 6'd63;

    localparam logic [ERR_W-1:0] E_NONE = 3'd0, E_COMMENT = 3'd1, E_SLASH = 3'd2,
        E_HEX = 3'd3, E_OCT = 3'd4, E_CHAR = 3'd5;

    // one result of the scanner
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  val;
        logic [ERR_W-1:0]  err;
    } token_t;

    // up to three results caused by one input beat
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } group_t;

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] p);
        case (p)
            "<": single_kind = K_LT;
            ">": single_kind = K_GT;
            "-": single_kind = K_MINUS;
            "=": single_kind = K_ASSIGN;
            "!": single_kind = K_BANG;
            "|": single_kind = K_BAR;
            "&": single_kind = K_AMP;
            "+": single_kind = K_PLUS;
            "*": single_kind = K_STAR;
            "%": single_kind = K_PCT;
            "^": single_kind = K_CARET;
            default: single_kind = K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] p,
                                                    input logic [7:0] c);
        pair_kind = K_NONE;
        case (p)
            "<": if (c == "=") pair_kind = K_LE; else if (c == "<") pair_kind = K_SHL;
                 else if (c == ":") pair_kind = K_LBRK; else if (c == "%") pair_kind = K_LBRC;
            ">": if (c == "=") pair_kind = K_GE; else if (c == ">") pair_kind = K_SHR;
            "-": if (c == ">") pair_kind = K_ARROW; else if (c == "-") pair_kind = K_DEC;
                 else if (c == "=") pair_kind = K_SUBEQ;
            "=": if (c == "=") pair_kind = K_EQ;
            "!": if (c == "=") pair_kind = K_NE;
            "|": if (c == "|") pair_kind = K_OROR; else if (c == "=") pair_kind = K_OREQ;
            "&": if (c == "&") pair_kind = K_ANDAND; else if (c == "=") pair_kind = K_ANDEQ;
            "+": if (c == "+") pair_kind = K_INC; else if (c == "=") pair_kind = K_ADDEQ;
            ":": if (c == ">") pair_kind = K_RBRK;
            "*": if (c == "=") pair_kind = K_MULEQ;
            "%": if (c == ">") pair_kind = K_RBRC; else if (c == "=") pair_kind = K_MODEQ;
                 else if (c == ":") pair_kind = K_HASH;
            "^": if (c == "=") pair_kind = K_XOREQ;
            default: pair_kind = K_NONE;
        endcase
    endfunction
endpackage
`default_nettype wire

/* design/cts_if.sv */
// ----------------------------------------------------------------------------
// cts channel interfaces
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
`default_nettype none
interface cts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       final_char;
    modport source (output valid, char_code, final_char, input ready);
    modport sink   (input valid, char_code, final_char, output ready);
endinterface

interface cts_token_if;
    logic                       valid;
    logic                       ready;
    logic [cts_pkg::KIND_W-1:0] token_kind;
    logic [cts_pkg::LEN_W-1:0]  token_length;
    logic [cts_pkg::VAL_W-1:0]  const_value;
    logic [cts_pkg::ERR_W-1:0]  error_code;
    logic                       run_end;
    modport source (output valid, token_kind, token_length, const_value, error_code,
                    run_end, input ready);
    modport sink   (input valid, token_kind, token_length, const_value, error_code,
                    run_end, output ready);
endinterface
`default_nettype wire

/* design/c_subset_token_scanner.sv */
// ----------------------------------------------------------------------------
// c_subset_token_scanner: streaming lexer for a subset of C
// Top level joining the classifying front and the token sequencer.
// ----------------------------------------------------------------------------
// One source byte is taken each cycle unless the queue is full; the scanner
// state updates in fixed logic, so bytes stream at one per cycle while the
// queue has room. Each byte yields up to three tokens, held as one group in a
// four-entry queue and sent one token per beat; input stalls only while the
// queue is full.
`default_nettype none
module c_subset_token_scanner #(
    parameter int LENGTH_BITS = cts_pkg::LENGTH_BITS_DEF,
    parameter int VALUE_BITS  = cts_pkg::VALUE_BITS_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    cts_byte_if.sink     src,
    cts_token_if.source  tok
);
    cts_pkg::group_t grp;
    logic            grp_valid, grp_ready;

    cts_front #(.LENGTH_BITS(LENGTH_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .clk, .rst_n,
        .in_valid(src.valid), .in_char(src.char_code), .in_final(src.final_char),
        .grp_ready, .in_ready(src.ready), .grp_valid, .grp
    );

    cts_back u_back (.clk, .rst_n, .grp_valid, .grp, .grp_ready, .tok);
endmodule
`default_nettype wire

/* design/cts_front.sv */
// ----------------------------------------------------------------------------
// cts_front: scanner state and classification
// Takes one byte a beat and produces the group of results it causes.
// ----------------------------------------------------------------------------
`default_nettype none
module cts_front #(
    parameter int LENGTH_BITS = cts_pkg::LENGTH_BITS_DEF,
    parameter int VALUE_BITS  = cts_pkg::VALUE_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_char,
    input  wire logic           in_final,
    input  wire logic           grp_ready,
    output logic                in_ready,
    output logic                grp_valid,
    output cts_pkg::group_t     grp
);
    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_OP, M_IDENT, M_DEC, M_OCT, M_HEX
    } mode_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    mode_t                   mode_reg, mode_next;
    logic [7:0]              pend_reg, pend_next;
    logic [LENGTH_BITS-1:0]  len_reg, len_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [2:0]              kw_reg, kw_next;
    logic                    octbad_reg, octbad_next;
    logic                    star_reg, star_next;
    logic                    err_reg, err_next;

    cts_pkg::token_t         res [3];
    logic [1:0]              n;
    logic [LENGTH_BITS-1:0]  len_inc;
    logic [cts_pkg::LEN_W-1:0] len_out;
    logic [cts_pkg::VAL_W-1:0] val_out;
    logic                    fire;

    assign in_ready = grp_ready;
    assign fire     = in_valid && in_ready;
    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;

    // widths adapt when the parameters differ from the field widths
    always_comb
    begin
        len_out = '0;
        val_out = '0;
        for (int i = 0; i < cts_pkg::LEN_W; i++)
            if (i < LENGTH_BITS) len_out[i] = len_reg[i];
        for (int i = 0; i < cts_pkg::VAL_W; i++)
            if (i < VALUE_BITS) val_out[i] = acc_reg[i];
    end

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= "0" && c <= "9";
    endfunction

    always_comb
    begin
        logic                    consumed;
        logic                    hexd;
        logic [3:0]              hv;
        logic [cts_pkg::KIND_W-1:0] k;
        logic [7:0]              c;
        c = in_char;
        mode_next = mode_reg; pend_next = pend_reg; len_next = len_reg;
        acc_next = acc_reg; kw_next = kw_reg; octbad_next = octbad_reg;
        star_next = star_reg; err_next = err_reg;
        for (int i = 0; i < 3; i++) res[i] = '0;
        n = 2'd0;
        consumed = 1'b0;
        hexd = 1'b0; hv = 4'd0; k = cts_pkg::K_NONE;
        if (is_digit(c)) begin hexd = 1'b1; hv = c[3:0]; end
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
        begin
            hexd = 1'b1; hv = 4'(c[3:0] + 4'd9);
        end
        if (!err_reg)
        begin
            unique case (mode_reg)
                M_COMMENT:
                begin
                    consumed = 1'b1;
                    if (star_reg && c == "/")
                    begin
                        mode_next = M_IDLE; star_next = 1'b0;
                    end
                    else star_next = (c == "*");
                end
                M_SLASH:
                begin
                    consumed = 1'b1;
                    if (c == "*") begin mode_next = M_COMMENT; star_next = 1'b0; end
                    else
                    begin
                        res[n].err = cts_pkg::E_SLASH; n = n + 1'b1;
                        err_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_OP:
                begin
                    k = cts_pkg::pair_kind(pend_reg, c);
                    mode_next = M_IDLE;
                    if (k != cts_pkg::K_NONE)
                    begin
                        res[n].kind = k; n = n + 1'b1; consumed = 1'b1;
                    end
                    else
                    begin
                        k = cts_pkg::single_kind(pend_reg);
                        if (k == cts_pkg::K_NONE)
                        begin
                            res[n].err = cts_pkg::E_CHAR; n = n + 1'b1;
                            err_next = 1'b1; consumed = 1'b1;
                        end
                        else begin res[n].kind = k; n = n + 1'b1; end
                    end
                end
                M_IDENT:
                begin
                    if (is_letter(c) || is_digit(c))
                    begin
                        consumed = 1'b1; len_next = len_inc;
                        if (kw_reg == 3'd1 && c == "f") kw_next = 3'd2;
                        else if (kw_reg == 3'd1 && c == "n") kw_next = 3'd3;
                        else if (kw_reg == 3'd3 && c == "t") kw_next = 3'd4;
                        else kw_next = 3'd0;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        if (kw_reg == 3'd2) res[n].kind = cts_pkg::K_IF;
                        else if (kw_reg == 3'd4) res[n].kind = cts_pkg::K_INT;
                        else begin res[n].kind = cts_pkg::K_IDENT; res[n].len = len_out; end
                        n = n + 1'b1;
                    end
                end
                M_DEC:
                begin
                    if (is_digit(c))
                    begin
                        consumed = 1'b1; len_next = len_inc;
                        acc_next = VALUE_BITS'((acc_reg << 3) + (acc_reg << 1)
                                   + VALUE_BITS'(c[3:0]));
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        res[n].kind = cts_pkg::K_CONST; res[n].len = len_out;
                        res[n].val = val_out; n = n + 1'b1;
                    end
                end
                M_OCT:
                begin
                    if (is_digit(c))
                    begin
                        consumed = 1'b1; len_next = len_inc;
                        if (c == "8" || c == "9") octbad_next = 1'b1;
                        acc_next = VALUE_BITS'((acc_reg << 3) + VALUE_BITS'(c[3:0]));
                    end
                    else if ((c == "x" || c == "X") && len_reg == LENGTH_BITS'(1))
                    begin
                        consumed = 1'b1; mode_next = M_HEX; len_next = len_inc;
                    end
                    else if (octbad_reg)
                    begin
                        consumed = 1'b1; res[n].err = cts_pkg::E_OCT; n = n + 1'b1;
                        err_next = 1'b1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        res[n].kind = cts_pkg::K_CONST; res[n].len = len_out;
                        res[n].val = val_out; n = n + 1'b1;
                    end
                end
                M_HEX:
                begin
                    if (hexd)
                    begin
                        consumed = 1'b1; len_next = len_inc;
                        acc_next = VALUE_BITS'((acc_reg << 4) | VALUE_BITS'(hv));
                    end
                    else if (is_letter(c))
                    begin
                        consumed = 1'b1; res[n].err = cts_pkg::E_HEX; n = n + 1'b1;
                        err_next = 1'b1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        res[n].kind = cts_pkg::K_CONST; res[n].len = len_out;
                        res[n].val = val_out; n = n + 1'b1;
                    end
                end
                default: consumed = 1'b0;
            endcase
            if (!consumed)
            begin
                mode_next = M_IDLE;
                case (c)
                    " ", 8'h09, 8'h0B, 8'h0C, 8'h0A, 8'h0D, 8'h00: ;
                    "/": mode_next = M_SLASH;
                    "~": begin res[n].kind = cts_pkg::K_TILDE; n = n + 1'b1; end
                    "?": begin res[n].kind = cts_pkg::K_QUEST; n = n + 1'b1; end
                    "[": begin res[n].kind = cts_pkg::K_LBRK; n = n + 1'b1; end
                    "]": begin res[n].kind = cts_pkg::K_RBRK; n = n + 1'b1; end
                    "{": begin res[n].kind = cts_pkg::K_LBRC; n = n + 1'b1; end
                    "}": begin res[n].kind = cts_pkg::K_RBRC; n = n + 1'b1; end
                    "(": begin res[n].kind = cts_pkg::K_LPAR; n = n + 1'b1; end
                    ")": begin res[n].kind = cts_pkg::K_RPAR; n = n + 1'b1; end
                    ";": begin res[n].kind = cts_pkg::K_SEMI; n = n + 1'b1; end
                    ",": begin res[n].kind = cts_pkg::K_COMMA; n = n + 1'b1; end
                    "<", ">", "-", "=", "!", "|", "&", "+", "*", "%", "^", ":":
                    begin
                        mode_next = M_OP; pend_next = c;
                    end
                    default:
                    begin
                        len_next = LENGTH_BITS'(1); acc_next = '0;
                        if (is_letter(c))
                        begin
                            mode_next = M_IDENT; kw_next = (c == "i") ? 3'd1 : 3'd0;
                        end
                        else if (c == "0")
                        begin
                            mode_next = M_OCT; octbad_next = 1'b0;
                        end
                        else if (is_digit(c))
                        begin
                            mode_next = M_DEC; acc_next = VALUE_BITS'(c[3:0]);
                        end
                        else
                        begin
                            res[n].err = cts_pkg::E_CHAR; n = n + 1'b1; err_next = 1'b1;
                        end
                    end
                endcase
            end
        end
        if (in_final)
        begin
            // close whatever the beat left open; the new state is what counts
            if (!err_next)
            begin
                unique case (mode_next)
                    M_COMMENT: begin res[n].err = cts_pkg::E_COMMENT; n = n + 1'b1; end
                    M_SLASH:   begin res[n].err = cts_pkg::E_SLASH; n = n + 1'b1; end
                    M_OP:
                    begin
                        k = cts_pkg::single_kind(pend_next);
                        if (k == cts_pkg::K_NONE) res[n].err = cts_pkg::E_CHAR;
                        else res[n].kind = k;
                        n = n + 1'b1;
                    end
                    M_IDENT:
                    begin
                        if (kw_next == 3'd2) res[n].kind = cts_pkg::K_IF;
                        else if (kw_next == 3'd4) res[n].kind = cts_pkg::K_INT;
                        else
                        begin
                            res[n].kind = cts_pkg::K_IDENT;
                            for (int i = 0; i < cts_pkg::LEN_W; i++)
                                if (i < LENGTH_BITS) res[n].len[i] = len_next[i];
                        end
                        n = n + 1'b1;
                    end
                    M_DEC, M_HEX, M_OCT:
                    begin
                        if (mode_next == M_OCT && octbad_next) res[n].err = cts_pkg::E_OCT;
                        else
                        begin
                            res[n].kind = cts_pkg::K_CONST;
                            for (int i = 0; i < cts_pkg::LEN_W; i++)
                                if (i < LENGTH_BITS) res[n].len[i] = len_next[i];
                            for (int i = 0; i < cts_pkg::VAL_W; i++)
                                if (i < VALUE_BITS) res[n].val[i] = acc_next[i];
                        end
                        n = n + 1'b1;
                    end
                    default: ;
                endcase
            end
            res[n] = '0; res[n].kind = cts_pkg::K_EOI; n = n + 1'b1;
            mode_next = M_IDLE; pend_next = '0; len_next = '0; acc_next = '0;
            kw_next = '0; octbad_next = 1'b0; star_next = 1'b0; err_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; pend_reg <= '0; len_reg <= '0; acc_reg <= '0;
            kw_reg <= '0; octbad_reg <= 1'b0; star_reg <= 1'b0; err_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next; pend_reg <= pend_next; len_reg <= len_next;
            acc_reg <= acc_next; kw_reg <= kw_next; octbad_reg <= octbad_next;
            star_reg <= star_next; err_reg <= err_next;
        end
    end

    assign grp_valid = fire && (n != 2'd0);
    assign grp.count = n;
    assign grp.t0 = res[0];
    assign grp.t1 = res[1];
    assign grp.t2 = res[2];
endmodule
`default_nettype wire

/* design/cts_back.sv */
// ----------------------------------------------------------------------------
// cts_back: result queue and token sequencer
// Holds groups in a short queue and sends their tokens one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module cts_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        grp_valid,
    input  cts_pkg::group_t  grp,
    output logic             grp_ready,
    cts_token_if.source      tok
);
    localparam int DEPTH = cts_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    cts_pkg::group_t  mem [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;
    logic [1:0]       idx_reg;
    cts_pkg::group_t  head;
    cts_pkg::token_t  cur;
    logic             push, pop, last;

    assign head = mem[rd_reg];
    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = head.t0;
            2'd1:    cur = head.t1;
            default: cur = head.t2;
        endcase
    end
    assign last      = (idx_reg + 2'd1) == head.count;
    assign grp_ready = cnt_reg != (AW+1)'(DEPTH);
    assign push      = grp_valid && grp_ready;
    assign pop       = tok.valid && tok.ready && last;

    assign tok.valid        = cnt_reg != '0;
    assign tok.token_kind   = cur.kind;
    assign tok.token_length = cur.len;
    assign tok.const_value  = cur.val;
    assign tok.error_code   = cur.err;
    assign tok.run_end      = last;

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0; idx_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= AW'(wr_reg + 1'b1);
            if (pop) rd_reg <= AW'(rd_reg + 1'b1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
            // advance within the group, restart at its end
            if (tok.valid && tok.ready) idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end
endmodule
`default_nettype wire

/* design/cts_checker.sv */
// ----------------------------------------------------------------------------
// cts_checker: port-level checks of the token scanner
// Watches the top-level channels and flags broken token sequences.
// ----------------------------------------------------------------------------
`default_nettype none
module cts_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [cts_pkg::KIND_W-1:0] token_kind,
    input wire logic [cts_pkg::LEN_W-1:0]  token_length,
    input wire logic [cts_pkg::VAL_W-1:0]  const_value,
    input wire logic [cts_pkg::ERR_W-1:0]  error_code,
    input wire logic                       run_end
);
    // an end token closes its byte's run
    a_eoi_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == cts_pkg::K_EOI |-> run_end)
        else $error("end token not last of run");
    // errors carry kind zero and no payload
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != cts_pkg::E_NONE |->
        token_kind == '0 && token_length == '0 && const_value == '0)
        else $error("error result with payload");
    // only constants carry a value
    a_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != cts_pkg::K_CONST |-> const_value == '0)
        else $error("value on non-constant");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("stalled beat changed");
endmodule

bind c_subset_token_scanner cts_checker u_cts_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(tok.valid), .out_ready(tok.ready),
    .token_kind(tok.token_kind), .token_length(tok.token_length),
    .const_value(tok.const_value), .error_code(tok.error_code), .run_end(tok.run_end)
);
`default_nettype wire
